/* rtl/core/cswg_pkg.sv */
// cswg_pkg: shared constants, tables and types of the cosine-sum window generator
// holds the window constant table, the cordic angle table and the side-band struct
// depends on nothing
package cswg_pkg;

	// sizes of the fields and of the internal datapath
	localparam int MAX_LENGTH    = 4096;
	localparam int FRAC_BITS     = 16;
	localparam int IDX_W         = 12;
	localparam int LEN_W         = 13;
	localparam int TYPE_W        = 3;
	localparam int COEF_W        = 18;
	localparam int PH_W          = 32;
	localparam int CW            = 32;
	localparam int A_W           = 30;
	localparam int LANES         = 4;
	localparam int CORDIC_STEPS  = 24;
	localparam int DIV_BITS      = 4;
	localparam int DIV_STAGES    = PH_W / DIV_BITS;
	localparam int CFG_IDX_W     = 1;

	localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(1024);
	localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032875;

	// window type codes
	localparam logic [TYPE_W-1:0] WIN_HANN            = 3'd0;
	localparam logic [TYPE_W-1:0] WIN_HAMMING         = 3'd1;
	localparam logic [TYPE_W-1:0] WIN_BLACKMAN        = 3'd2;
	localparam logic [TYPE_W-1:0] WIN_BLACKMAN_HARRIS = 3'd3;
	localparam logic [TYPE_W-1:0] WIN_FLAT_TOP        = 3'd4;
	localparam logic [TYPE_W-1:0] WIN_NUTTALL         = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

	// arctangent of 2^-i as a fraction of a turn
	localparam logic signed [CW-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81
	};

	// window constants a0..a4 in q30, one row per window type
	localparam logic [A_W-1:0] COEF_TAB [0:5][0:4] = '{
		'{30'd536870912, 30'd536870912, 30'd0,         30'd0,        30'd0},
		'{30'd579820585, 30'd493921239, 30'd0,         30'd0,        30'd0},
		'{30'd450971566, 30'd536870912, 30'd85899346,  30'd0,        30'd0},
		'{30'd385204879, 30'd524297395, 30'd151698245, 30'd12541305, 30'd0},
		'{30'd231476135, 30'd447354753, 30'd297709049, 30'd89742211, 30'd7459680},
		'{30'd390393092, 30'd525250341, 30'd146672596, 30'd11425794, 30'd0}
	};

	typedef logic [PH_W-1:0] phase_t;
	typedef logic signed [CW-1:0] cw_t;

	// what travels beside the data down the pipeline
	typedef struct packed {
		logic              err;
		logic [TYPE_W-1:0] typ;
	} cswg_side_t;

	// window constant lookup, unknown types read as zero
	function automatic logic [A_W-1:0] win_coef(input logic [TYPE_W-1:0] typ,
			input int unsigned k);
		logic [A_W-1:0] v;
		v = '0;
		if (typ <= WIN_NUTTALL && k < 5) begin
			v = COEF_TAB[typ][k];
		end
		return v;
	endfunction

endpackage

/* rtl/core/cosine_sum_window_generator.sv */
// cosine_sum_window_generator: top level of the window coefficient generator
// holds the configuration registers and the output skid, joins phase, cordic and sum
// depends on cswg_pkg, cswg_phase, cswg_cordic, cswg_sum
//
//   channel   dir  fields (low bit first)
//   s_axis    in   tdata: sample_index[11:0]
//   m_axis    out  tdata: coefficient[17:0]; tuser: index_error
//   cfg       in   cfg_index 0 window_type, 1 window_length; cfg_data
//
// one index is taken every clock while the skid register is empty; its result passes the
// residue stages, the 8-stage phase divider, the 24-stage cordic and the sum into the output register
// arst_n clears all valid bits and sets window_type 0, window_length 1024
// a stalled output parks one result in a skid register, the pipeline
// then holds until the skid drains; nothing is lost or repeated
module cosine_sum_window_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,   // sample_index
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata,   // coefficient
	output logic                              m_axis_tuser,   // index_error
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cswg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cswg_pkg::LEN_W-1:0]        cfg_data
);
	import cswg_pkg::*;

	logic [TYPE_W-1:0]   type_q;
	logic [LEN_W-1:0]    length_q;
	logic                en;

	logic                ph_valid;
	cswg_side_t          ph_side;
	phase_t              ph_phase [0:LANES-1];

	logic                co_valid;
	cswg_side_t          co_side;
	cw_t                 co_cos [0:LANES-1];

	logic                pipe_valid, pipe_err;
	logic signed [COEF_W-1:0] pipe_coef;

	logic                out_valid_q, out_err_q, skid_valid_q, skid_err_q;
	logic signed [COEF_W-1:0] out_coef_q, skid_coef_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q   <= WIN_HANN;
			length_q <= LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_TYPE:   type_q   <= cfg_data[TYPE_W-1:0];
				REG_WINDOW_LENGTH: length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves while the skid is free
	assign en            = !skid_valid_q;
	assign s_axis_tready = en;

	cswg_phase u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.in_index   (s_axis_tdata[IDX_W-1:0]),
		.cfg_type   (type_q),
		.cfg_length (length_q),
		.out_valid  (ph_valid),
		.out_side   (ph_side),
		.out_phase  (ph_phase)
	);

	cswg_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ph_valid),
		.in_side   (ph_side),
		.in_phase  (ph_phase),
		.out_valid (co_valid),
		.out_side  (co_side),
		.out_cos   (co_cos)
	);

	cswg_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (co_valid),
		.in_side   (co_side),
		.in_cos    (co_cos),
		.out_valid (pipe_valid),
		.out_err   (pipe_err),
		.out_coef  (pipe_coef)
	);

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= pipe_valid;
			end
		end else if (en && pipe_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output register and skid data
	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_coef_q <= skid_coef_q;
				out_err_q  <= skid_err_q;
			end else begin
				out_coef_q <= pipe_coef;
				out_err_q  <= pipe_err;
			end
		end else if (en && pipe_valid) begin
			skid_coef_q <= pipe_coef;
			skid_err_q  <= pipe_err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(24 - COEF_W){1'b0}}, out_coef_q};
	assign m_axis_tuser  = out_err_q;

endmodule

/* rtl/core/cswg_phase.sv */
// cswg_phase: index check, phase remainders and the pipelined phase divider
// turns a sample index into four turn fractions (k*n mod D) / D, k = 1..4
// depends on cswg_pkg
module cswg_phase (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [cswg_pkg::IDX_W-1:0]      in_index,
	input  logic [cswg_pkg::TYPE_W-1:0]     cfg_type,
	input  logic [cswg_pkg::LEN_W-1:0]      cfg_length,
	output logic                            out_valid,
	output cswg_pkg::cswg_side_t            out_side,
	output cswg_pkg::phase_t                out_phase [0:cswg_pkg::LANES-1]
);
	import cswg_pkg::*;

	// add two residues below den and reduce once
	function automatic logic [LEN_W-1:0] mod_add(input logic [LEN_W-1:0] a,
			input logic [LEN_W-1:0] b, input logic [LEN_W-1:0] d);
		logic [LEN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, d}) begin
			s = s - {1'b0, d};
		end
		return s[LEN_W-1:0];
	endfunction

	logic [LEN_W-1:0]  len_sat, den_c, r_c;
	logic [TYPE_W-1:0] typ_c;
	logic              err_c;

	logic              valid_s1, dz_s1;
	cswg_side_t        side_s1;
	logic [LEN_W-1:0]  den_s1, r_s1;

	logic              valid_s2, dz_s2;
	cswg_side_t        side_s2;
	logic [LEN_W-1:0]  den_s2, r_s2, m2_s2;

	// divider stage arrays, element 0 is loaded by the residue stage
	logic              dv_valid_s [0:DIV_STAGES];
	logic              dv_dz_s    [0:DIV_STAGES];
	cswg_side_t        dv_side_s  [0:DIV_STAGES];
	logic [LEN_W-1:0]  dv_den_s   [0:DIV_STAGES];
	logic [LEN_W-1:0]  dv_rem_s   [0:DIV_STAGES][0:LANES-1];
	phase_t            dv_q_s     [0:DIV_STAGES][0:LANES-1];

	// length clamp, type fallback, denominator and range check
	always_comb begin
		len_sat = cfg_length;
		if (32'(cfg_length) > 32'(MAX_LENGTH)) begin
			len_sat = LEN_W'(MAX_LENGTH);
		end
		typ_c = (cfg_type > WIN_NUTTALL) ? WIN_HANN : cfg_type;
		den_c = (typ_c == WIN_BLACKMAN_HARRIS) ? len_sat : len_sat - LEN_W'(1);
		err_c = LEN_W'(in_index) >= len_sat;
		r_c   = (LEN_W'(in_index) == den_c) ? '0 : LEN_W'(in_index);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			dv_valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s1      <= in_valid;
			valid_s2      <= valid_s1;
			dv_valid_s[0] <= valid_s2;
		end
	end

	// residues of k*n for k = 1..4
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.err <= err_c;
			side_s1.typ <= typ_c;
			den_s1      <= den_c;
			dz_s1       <= (den_c == '0);
			r_s1        <= r_c;

			side_s2 <= side_s1;
			den_s2  <= den_s1;
			dz_s2   <= dz_s1;
			r_s2    <= r_s1;
			m2_s2   <= mod_add(r_s1, r_s1, den_s1);

			dv_side_s[0]   <= side_s2;
			dv_den_s[0]    <= den_s2;
			dv_dz_s[0]     <= dz_s2;
			dv_rem_s[0][0] <= r_s2;
			dv_rem_s[0][1] <= m2_s2;
			dv_rem_s[0][2] <= mod_add(m2_s2, r_s2, den_s2);
			dv_rem_s[0][3] <= mod_add(m2_s2, m2_s2, den_s2);
			for (int l = 0; l < LANES; l++) begin
				dv_q_s[0][l] <= '0;
			end
		end
	end

	// restoring divider, four quotient bits per stage
	for (genvar st = 0; st < DIV_STAGES; st++) begin : g_div
		logic [LEN_W-1:0] rem_n [0:LANES-1];
		phase_t           q_n   [0:LANES-1];

		always_comb begin
			logic [LEN_W:0] t;
			t = '0;
			for (int l = 0; l < LANES; l++) begin
				rem_n[l] = dv_rem_s[st][l];
				q_n[l]   = dv_q_s[st][l];
				for (int b = 0; b < DIV_BITS; b++) begin
					t = {rem_n[l], 1'b0};
					if (t >= {1'b0, dv_den_s[st]}) begin
						t        = t - {1'b0, dv_den_s[st]};
						q_n[l]   = {q_n[l][PH_W-2:0], 1'b1};
					end else begin
						q_n[l]   = {q_n[l][PH_W-2:0], 1'b0};
					end
					rem_n[l] = t[LEN_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s[st+1] <= 1'b0;
			end else if (en) begin
				dv_valid_s[st+1] <= dv_valid_s[st];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[st+1] <= dv_side_s[st];
				dv_den_s[st+1]  <= dv_den_s[st];
				dv_dz_s[st+1]   <= dv_dz_s[st];
				for (int l = 0; l < LANES; l++) begin
					dv_rem_s[st+1][l] <= rem_n[l];
					dv_q_s[st+1][l]   <= q_n[l];
				end
			end
		end
	end

	// a zero denominator gives phase zero
	assign out_valid = dv_valid_s[DIV_STAGES];
	assign out_side  = dv_side_s[DIV_STAGES];
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_phase[l] = dv_dz_s[DIV_STAGES] ? '0 : dv_q_s[DIV_STAGES][l];
		end
	end

endmodule

/* rtl/core/cswg_cordic.sv */
// cswg_cordic: four-lane pipelined cordic, one rotation per stage
// gives q30 cosines of four turn fractions, quadrant folded at the end
// depends on cswg_pkg
module cswg_cordic (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  cswg_pkg::cswg_side_t   in_side,
	input  cswg_pkg::phase_t       in_phase [0:cswg_pkg::LANES-1],
	output logic                   out_valid,
	output cswg_pkg::cswg_side_t   out_side,
	output cswg_pkg::cw_t          out_cos [0:cswg_pkg::LANES-1]
);
	import cswg_pkg::*;

	logic       cv_s    [0:CORDIC_STEPS];
	cswg_side_t cside_s [0:CORDIC_STEPS];
	cw_t        cx_s    [0:CORDIC_STEPS][0:LANES-1];
	cw_t        cy_s    [0:CORDIC_STEPS][0:LANES-1];
	cw_t        cz_s    [0:CORDIC_STEPS][0:LANES-1];
	logic [1:0] quad_s  [0:CORDIC_STEPS][0:LANES-1];

	logic       valid_sc;
	cswg_side_t side_sc;
	cw_t        cos_sc [0:LANES-1];

	// load start vector and quadrant-reduced angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else if (en) begin
			cv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cside_s[0] <= in_side;
			for (int l = 0; l < LANES; l++) begin
				cx_s[0][l]   <= CORDIC_GAIN;
				cy_s[0][l]   <= '0;
				cz_s[0][l]   <= $signed({2'b00, in_phase[l][PH_W-3:0]});
				quad_s[0][l] <= in_phase[l][PH_W-1:PH_W-2];
			end
		end
	end

	// one rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else if (en) begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cside_s[i+1] <= cside_s[i];
				for (int l = 0; l < LANES; l++) begin
					quad_s[i+1][l] <= quad_s[i][l];
					if (!cz_s[i][l][CW-1]) begin
						cx_s[i+1][l] <= cx_s[i][l] - (cy_s[i][l] >>> i);
						cy_s[i+1][l] <= cy_s[i][l] + (cx_s[i][l] >>> i);
						cz_s[i+1][l] <= cz_s[i][l] - ATAN_TAB[i];
					end else begin
						cx_s[i+1][l] <= cx_s[i][l] + (cy_s[i][l] >>> i);
						cy_s[i+1][l] <= cy_s[i][l] - (cx_s[i][l] >>> i);
						cz_s[i+1][l] <= cz_s[i][l] + ATAN_TAB[i];
					end
				end
			end
		end
	end

	// quadrant fold: odd quadrants take y, quadrants one and two negate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sc <= 1'b0;
		end else if (en) begin
			valid_sc <= cv_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		cw_t base;
		if (en) begin
			side_sc <= cside_s[CORDIC_STEPS];
			for (int l = 0; l < LANES; l++) begin
				base = quad_s[CORDIC_STEPS][l][0] ? cy_s[CORDIC_STEPS][l]
					: cx_s[CORDIC_STEPS][l];
				cos_sc[l] <= (quad_s[CORDIC_STEPS][l][1] ^ quad_s[CORDIC_STEPS][l][0])
					? -base : base;
			end
		end
	end

	assign out_valid = valid_sc;
	assign out_side  = side_sc;
	assign out_cos   = cos_sc;

endmodule

/* rtl/core/cswg_sum.sv */
// cswg_sum: weighted cosine sum, rounding and saturation
// multiplies each cosine by its window constant and folds the terms into q2.16
// depends on cswg_pkg
module cswg_sum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  cswg_pkg::cswg_side_t                in_side,
	input  cswg_pkg::cw_t                       in_cos [0:cswg_pkg::LANES-1],
	output logic                                out_valid,
	output logic                                out_err,
	output logic signed [cswg_pkg::COEF_W-1:0]  out_coef
);
	import cswg_pkg::*;

	localparam int PROD_W = A_W + 1 + CW;
	localparam int ACC_W  = 36;
	localparam int SH     = 30 - FRAC_BITS;
	localparam logic signed [ACC_W-1:0] RND = (SH > 0) ? ACC_W'(64'sd1 <<< (SH - 1)) : '0;
	localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (COEF_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(64'sd1 <<< (COEF_W - 1));

	logic                      valid_s1, valid_s2, valid_s3;
	logic                      err_s1, err_s2, err_s3;
	logic [A_W-1:0]            a0_s1;
	logic signed [PROD_W-1:0]  prod_s1 [0:LANES-1];
	logic signed [ACC_W-1:0]   acc_s2;
	logic signed [COEF_W-1:0]  coef_s3;

	logic signed [ACC_W-1:0]   acc_c, rnd_c;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// alternating sum of floored products
	always_comb begin
		logic signed [ACC_W-1:0] term;
		acc_c = ACC_W'($signed({1'b0, a0_s1}));
		for (int l = 0; l < LANES; l++) begin
			term = ACC_W'(prod_s1[l] >>> 30);
			if (l % 2 == 0) begin
				acc_c = acc_c - term;
			end else begin
				acc_c = acc_c + term;
			end
		end
	end

	// round half up to the output fraction
	assign rnd_c = (acc_s2 + RND) >>> SH;

	always_ff @(posedge clk) begin
		if (en) begin
			// constant times cosine
			err_s1 <= in_side.err;
			a0_s1  <= win_coef(in_side.typ, 0);
			for (int l = 0; l < LANES; l++) begin
				prod_s1[l] <= $signed({1'b0, win_coef(in_side.typ, l + 1)}) * in_cos[l];
			end

			err_s2 <= err_s1;
			acc_s2 <= acc_c;

			// saturate, out of range index reads zero
			err_s3 <= err_s2;
			if (err_s2) begin
				coef_s3 <= '0;
			end else if (rnd_c > OUT_MAX) begin
				coef_s3 <= COEF_W'(OUT_MAX);
			end else if (rnd_c < OUT_MIN) begin
				coef_s3 <= COEF_W'(OUT_MIN);
			end else begin
				coef_s3 <= COEF_W'(rnd_c);
			end
		end
	end

	assign out_valid = valid_s3;
	assign out_err   = err_s3;
	assign out_coef  = coef_s3;

endmodule

/* dv/tb.sv */
// tb: self-checking testbench of the cosine-sum window generator
// predicts each coefficient with its own cordic and phase math, checks the output stream in order
// depends on cswg_pkg and cosine_sum_window_generator
`timescale 1ns / 100ps

module tb;
	import cswg_pkg::*;

	localparam int  CYCLE_LIMIT   = 400000;
	localparam int  DRAIN_CYCLES  = 60;
	localparam longint OUT_HI     = 131071;
	localparam longint OUT_LO     = -131072;

	typedef struct {
		logic signed [COEF_W-1:0] coef;
		logic                     err;
	} window_point_t;

	// arctangent of 2^-i in turns, 2^32 per turn
	localparam longint ATAN_TURNS [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
		5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304, 652, 326, 163, 81
	};

	// a0..a4 in q30 for hann, hamming, blackman, blackman-harris, flat top, nuttall
	localparam longint WIN_A [0:5][0:4] = '{
		'{536870912, 536870912, 0, 0, 0},
		'{579820585, 493921239, 0, 0, 0},
		'{450971566, 536870912, 85899346, 0, 0},
		'{385204879, 524297395, 151698245, 12541305, 0},
		'{231476135, 447354753, 297709049, 89742211, 7459680},
		'{390393092, 525250341, 146672596, 11425794, 0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;     // sample_index
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [23:0]       m_axis_tdata;          // coefficient
	logic              m_axis_tuser;          // index_error
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]  cfg_data = '0;

	// shadow of the configuration registers
	logic [TYPE_W-1:0] cur_type = WIN_HANN;
	logic [LEN_W-1:0]  cur_length = LENGTH_RESET;

	window_point_t pending_points[$];
	int  mismatch_count = 0;
	int  results_seen = 0;
	int  indices_sent = 0;
	int  range_errors_seen = 0;
	int  burst_left = 0;
	int  cycle_count = 0;
	int  stall_mode = 0;

	cosine_sum_window_generator u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cosine of a turn fraction in q30 through a 24-step cordic
	function automatic longint cordic_cos(input logic [31:0] ph);
		longint x, y, z, nx;
		x = 652032875;
		y = 0;
		z = longint'(ph[29:0]);
		for (int i = 0; i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - ATAN_TURNS[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + ATAN_TURNS[i];
			end
			x = nx;
		end
		case (ph[31:30])
			2'd0: return x;
			2'd1: return -y;
			2'd2: return -x;
			default: return y;
		endcase
	endfunction

	// window value for one index under the current settings
	function automatic window_point_t window_point(input logic [IDX_W-1:0] n);
		window_point_t p;
		longint unsigned len, den, m;
		logic [31:0] ph;
		longint acc, term, res;
		int t;
		len = (cur_length > MAX_LENGTH) ? MAX_LENGTH : cur_length;
		if (n >= len) begin
			p.coef = '0;
			p.err  = 1'b1;
			return p;
		end
		t = (cur_type > WIN_NUTTALL) ? int'(WIN_HANN) : int'(cur_type);
		den = (t == int'(WIN_BLACKMAN_HARRIS)) ? len : len - 1;
		acc = WIN_A[t][0];
		for (int k = 1; k <= 4; k++) begin
			ph = '0;
			if (den != 0) begin
				m = (longint'(k) * n) % den;
				ph = 32'((m << 32) / den);
			end
			term = (WIN_A[t][k] * cordic_cos(ph)) >>> 30;
			acc = (k % 2 == 1) ? acc - term : acc + term;
		end
		res = (acc + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (res > OUT_HI) res = OUT_HI;
		if (res < OUT_LO) res = OUT_LO;
		p.coef = COEF_W'(res);
		p.err  = 1'b0;
		return p;
	endfunction

	// request one index, bursts broken by random gaps
	task automatic send_index(input logic [IDX_W-1:0] n);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, n};
		do @(posedge clk); while (!s_axis_tready);
		pending_points.push_back(window_point(n));
		indices_sent++;
	endtask

	// let every requested point come back, then let the pipeline settle
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_WINDOW_TYPE) cur_type = val[TYPE_W-1:0];
		else cur_length = val;
	endtask

	// reset values: hann over 1024 points
	task automatic test_reset_defaults;
		send_index(12'd0);
		send_index(12'd512);
		send_index(12'd1023);
		send_index(12'd1024);
		send_index(12'hFFF);
	endtask

	// every window type, undefined codes included, over a short window
	task automatic test_window_types;
		write_reg(REG_WINDOW_LENGTH, 13'd16);
		for (int t = 0; t < 8; t++) begin
			write_reg(REG_WINDOW_TYPE, LEN_W'(t));
			send_index(12'd0);
			send_index(12'd7);
		end
	endtask

	// degenerate and oversize lengths
	task automatic test_length_edges;
		write_reg(REG_WINDOW_TYPE, LEN_W'(WIN_BLACKMAN_HARRIS));
		write_reg(REG_WINDOW_LENGTH, 13'd0);
		send_index(12'd0);
		write_reg(REG_WINDOW_LENGTH, 13'd1);
		send_index(12'd0);
		write_reg(REG_WINDOW_TYPE, LEN_W'(WIN_FLAT_TOP));
		send_index(12'd0);
		send_index(12'd1);
		write_reg(REG_WINDOW_LENGTH, 13'd2);
		send_index(12'd1);
		write_reg(REG_WINDOW_LENGTH, 13'h1FFF);
		send_index(12'hFFF);
		send_index(12'd2048);
	endtask

	// random settings, mostly in-range indices with a share beyond the length
	task automatic test_random_windows;
		int len;
		logic [IDX_W-1:0] n;
		while (indices_sent < 820) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(0, 3);
				1: len = $urandom_range(4097, 8191);
				2: len = 4096;
				3, 4: len = $urandom_range(4, 4096);
				default: len = $urandom_range(4, 64);
			endcase
			write_reg(REG_WINDOW_TYPE, {LEN_W'($urandom_range(0, 1023)) << TYPE_W} |
				LEN_W'($urandom_range(0, 7)));
			write_reg(REG_WINDOW_LENGTH, LEN_W'(len));
			repeat ($urandom_range(30, 90)) begin
				if ($urandom_range(0, 7) == 0 || len < 2) n = IDX_W'($urandom);
				else n = IDX_W'($urandom_range(0, ((len > 4096) ? 4096 : len) - 1));
				send_index(n);
			end
		end
	endtask

	// receiver stall pattern, switching between modes
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= (cycle_count % 7) > 2;
		endcase
	end

	// compare each result with the oldest predicted point
	always @(posedge clk) begin
		window_point_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tuser) range_errors_seen++;
			if (pending_points.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result coef=%0d err=%b",
					$signed(m_axis_tdata[COEF_W-1:0]), m_axis_tuser);
			end else begin
				want = pending_points.pop_front();
				if (m_axis_tdata[COEF_W-1:0] !== want.coef || m_axis_tuser !== want.err) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d: expected coef=%0d err=%b, got coef=%0d err=%b",
							results_seen, want.coef, want.err,
							$signed(m_axis_tdata[COEF_W-1:0]), m_axis_tuser);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_window_types();
		test_length_edges();
		test_random_windows();
		drain();
		if (pending_points.size() != 0) mismatch_count++;
		$display("checked %0d coefficients (%0d out of range) over all window types and lengths",
			results_seen, range_errors_seen);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
